@@ src/link_handshake_keepalive_fsm_core_macros.svh @@
// Assertion macros shared by the link handshake and keepalive engine.
`ifndef LINK_HANDSHAKE_KEEPALIVE_FSM_CORE_MACROS_SVH
`define LINK_HANDSHAKE_KEEPALIVE_FSM_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LHK_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("link engine check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define LHK_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("link engine check failed one cycle later");

`endif

@@ src/lhk_pkg.sv @@
// Types, codes and constants of the link handshake and keepalive engine.
`timescale 1ns / 1ps

package lhk_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned CFG_INDEX_W = 3;

    typedef enum logic [2:0] {
        LS_UNLINKED      = 3'd0,
        LS_CONNECTING    = 3'd1,
        LS_CONNECTED     = 3'd2,
        LS_SPURIOUS      = 3'd3,
        LS_DISCONNECTED  = 3'd4
    } link_state_t;

    // Request types carried in the input tuser.
    localparam logic [1:0] REQ_TICK_START = 2'd0;
    localparam logic [1:0] REQ_PACKET     = 2'd1;
    localparam logic [1:0] REQ_TICK_END   = 2'd2;

    // Received packet kinds.
    localparam logic [2:0] PK_HELLO_ACK = 3'd0;
    localparam logic [2:0] PK_HSK_ACK   = 3'd1;
    localparam logic [2:0] PK_SPAWN     = 3'd2;
    localparam logic [2:0] PK_UPDATE    = 3'd3;
    localparam logic [2:0] PK_DESPAWN   = 3'd4;
    localparam logic [2:0] PK_WORLD     = 3'd5;
    localparam logic [2:0] PK_PING_RESP = 3'd6;
    localparam logic [2:0] PK_OTHER     = 3'd7;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_RETRANSMIT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SILENCE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROBE      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEEPALIVE  = 3'd4;

    localparam logic [PERIOD_W-1:0] RST_RETRANSMIT = 16'd100;
    localparam logic [PERIOD_W-1:0] RST_TIMEOUT    = 16'd1000;
    localparam logic [PERIOD_W-1:0] RST_SILENCE    = 16'd100;
    localparam logic [PERIOD_W-1:0] RST_PROBE      = 16'd200;
    localparam logic [PERIOD_W-1:0] RST_KEEPALIVE  = 16'd1000;

    // Bits of the send-due-at-once flags.
    localparam int unsigned DUE_HELLO = 0;
    localparam int unsigned DUE_HSK   = 1;
    localparam int unsigned DUE_PROBE = 2;

    typedef struct packed {
        logic [PERIOD_W-1:0] retransmit;
        logic [PERIOD_W-1:0] timeout;
        logic [PERIOD_W-1:0] silence;
        logic [PERIOD_W-1:0] probe;
        logic [PERIOD_W-1:0] keepalive;
    } cfg_t;

    // True when at least lim milliseconds have gone by since the mark, modulo 2^32.
    function automatic logic elapsed(input logic [TIME_W-1:0] now,
                                     input logic [TIME_W-1:0] since,
                                     input logic [PERIOD_W-1:0] lim);
        logic [TIME_W-1:0] diff;
        diff = now - since;
        return diff >= {{(TIME_W-PERIOD_W){1'b0}}, lim};
    endfunction

endpackage

@@ src/lhk_cfg_regs.sv @@
// Configuration register bank with timer periods and limits.
`timescale 1ns / 1ps

module lhk_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              wr_en,
    input  logic [lhk_pkg::CFG_INDEX_W-1:0]   index,
    input  logic [lhk_pkg::PERIOD_W-1:0]      wdata,
    output lhk_pkg::cfg_t                     cfg
);

    lhk_pkg::cfg_t cfg_reg;
    lhk_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (index)
                lhk_pkg::CFG_RETRANSMIT: cfg_next.retransmit = wdata;
                lhk_pkg::CFG_TIMEOUT:    cfg_next.timeout    = wdata;
                lhk_pkg::CFG_SILENCE:    cfg_next.silence    = wdata;
                lhk_pkg::CFG_PROBE:      cfg_next.probe      = wdata;
                lhk_pkg::CFG_KEEPALIVE:  cfg_next.keepalive  = wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.retransmit <= lhk_pkg::RST_RETRANSMIT;
            cfg_reg.timeout    <= lhk_pkg::RST_TIMEOUT;
            cfg_reg.silence    <= lhk_pkg::RST_SILENCE;
            cfg_reg.probe      <= lhk_pkg::RST_PROBE;
            cfg_reg.keepalive  <= lhk_pkg::RST_KEEPALIVE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/link_handshake_keepalive_fsm_core.sv @@
// A result appears on m_tvalid in the cycle after its transaction is accepted.
// Throughput: one item per cycle; the only stall comes from the result register
// being full while m_tready is low.
// Reset (aresetn low, synchronous) returns the link to the unlinked state, clears timers,
// counters and the id, sets all send-due flags and restores the register defaults.
`timescale 1ns / 1ps
`include "link_handshake_keepalive_fsm_core_macros.svh"

module link_handshake_keepalive_fsm_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [2:0]    cfg_index,
    input  logic [15:0]   cfg_wdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,   // now_ms[31:0], offered_id[63:32]
    input  logic [5:0]    s_tuser,   // req_type[1:0], pkt_kind[4:2], pkt_len_ok[5]
    output logic          m_tvalid,
    input  logic          m_tready,
    // link_state[2:0], state_changed[3], send_hello[4], send_handshake[5],
    // send_ping[6], ping_number[38:7], send_input[39], input_number[71:40],
    // local_id[103:72], link_up[104], zero fill[111:105]
    output logic [111:0]  m_tdata
);

    lhk_pkg::cfg_t cfg;

    lhk_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cfg_wr_en),
        .index   (cfg_index),
        .wdata   (cfg_wdata),
        .cfg     (cfg)
    );

    // Input decode
    logic [1:0]  req;
    logic [2:0]  kind;
    logic        len_ok;
    logic [31:0] now;
    logic [31:0] offered;

    assign req     = s_tuser[1:0];
    assign kind    = s_tuser[4:2];
    assign len_ok  = s_tuser[5];
    assign now     = s_tdata[31:0];
    assign offered = s_tdata[63:32];

    // State
    lhk_pkg::link_state_t mode_reg, mode_next;
    logic [31:0] entered_reg, entered_next;
    logic [31:0] hello_at_reg, hello_at_next;
    logic [31:0] hsk_at_reg, hsk_at_next;
    logic [31:0] data_at_reg, data_at_next;
    logic [31:0] probe_at_reg, probe_at_next;
    logic [31:0] keep_at_reg, keep_at_next;
    logic [2:0]  due_reg, due_next;
    logic [31:0] ping_cnt_reg, ping_cnt_next;
    logic [31:0] input_cnt_reg, input_cnt_next;
    logic [31:0] id_reg, id_next;

    // Result register
    logic        m_valid_reg;
    logic [2:0]  o_state_reg;
    logic        o_changed_reg, o_hello_reg, o_hsk_reg, o_ping_reg, o_input_reg, o_up_reg;
    logic [31:0] o_ping_no_reg, o_input_no_reg, o_id_reg;

    logic acc;
    logic changed;
    logic hello_fire, hsk_fire, ping_fire, input_fire;
    logic el_timeout, el_silence, el_retx_hello, el_retx_hsk, el_probe, el_keep;

    assign s_tready = !m_valid_reg || m_tready;
    assign acc      = s_tvalid && s_tready;

    assign el_timeout    = lhk_pkg::elapsed(now, entered_reg, cfg.timeout);
    assign el_silence    = lhk_pkg::elapsed(now, data_at_reg, cfg.silence);
    assign el_retx_hello = lhk_pkg::elapsed(now, hello_at_reg, cfg.retransmit);
    assign el_retx_hsk   = lhk_pkg::elapsed(now, hsk_at_reg, cfg.retransmit);
    assign el_probe      = lhk_pkg::elapsed(now, probe_at_reg, cfg.probe);
    assign el_keep       = lhk_pkg::elapsed(now, keep_at_reg, cfg.keepalive);

    // Next link state
    always_comb begin
        mode_next    = mode_reg;
        entered_next = entered_reg;
        changed      = 1'b0;
        if (mode_reg != lhk_pkg::LS_DISCONNECTED) begin
            case (req)
                lhk_pkg::REQ_TICK_START: begin
                    case (mode_reg)
                        lhk_pkg::LS_UNLINKED, lhk_pkg::LS_CONNECTING,
                        lhk_pkg::LS_SPURIOUS: begin
                            if (el_timeout) begin
                                mode_next = lhk_pkg::LS_DISCONNECTED;
                                changed   = 1'b1;
                            end
                        end
                        lhk_pkg::LS_CONNECTED: begin
                            if (el_silence) begin
                                mode_next = lhk_pkg::LS_SPURIOUS;
                                changed   = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                lhk_pkg::REQ_PACKET: begin
                    if (len_ok) begin
                        case (kind)
                            lhk_pkg::PK_HELLO_ACK: begin
                                if (mode_reg == lhk_pkg::LS_UNLINKED) begin
                                    mode_next = lhk_pkg::LS_CONNECTING;
                                    changed   = 1'b1;
                                end
                            end
                            lhk_pkg::PK_HSK_ACK: begin
                                if (mode_reg == lhk_pkg::LS_CONNECTING) begin
                                    mode_next = lhk_pkg::LS_CONNECTED;
                                    changed   = 1'b1;
                                end
                            end
                            lhk_pkg::PK_UPDATE, lhk_pkg::PK_PING_RESP: begin
                                if (mode_reg == lhk_pkg::LS_SPURIOUS) begin
                                    mode_next = lhk_pkg::LS_CONNECTED;
                                    changed   = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
        if (changed) begin
            entered_next = now;
        end
    end

    // Sends, timestamps and counters
    always_comb begin
        hello_fire     = 1'b0;
        hsk_fire       = 1'b0;
        ping_fire      = 1'b0;
        input_fire     = 1'b0;
        hello_at_next  = hello_at_reg;
        hsk_at_next    = hsk_at_reg;
        data_at_next   = data_at_reg;
        probe_at_next  = probe_at_reg;
        keep_at_next   = keep_at_reg;
        due_next       = due_reg;
        id_next        = id_reg;
        if (mode_reg != lhk_pkg::LS_DISCONNECTED) begin
            case (req)
                lhk_pkg::REQ_TICK_START: begin
                    case (mode_reg)
                        lhk_pkg::LS_UNLINKED: begin
                            hello_fire = due_reg[lhk_pkg::DUE_HELLO] || el_retx_hello;
                        end
                        lhk_pkg::LS_CONNECTING: begin
                            hsk_fire = due_reg[lhk_pkg::DUE_HSK] || el_retx_hsk;
                        end
                        lhk_pkg::LS_SPURIOUS: begin
                            ping_fire = due_reg[lhk_pkg::DUE_PROBE] || el_probe;
                            if (ping_fire) begin
                                probe_at_next = now;
                                due_next[lhk_pkg::DUE_PROBE] = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                    if (hello_fire) begin
                        hello_at_next = now;
                        due_next[lhk_pkg::DUE_HELLO] = 1'b0;
                    end
                    if (hsk_fire) begin
                        hsk_at_next = now;
                        due_next[lhk_pkg::DUE_HSK] = 1'b0;
                    end
                end
                lhk_pkg::REQ_PACKET: begin
                    if (len_ok) begin
                        case (kind)
                            lhk_pkg::PK_HELLO_ACK: begin
                                if (mode_reg == lhk_pkg::LS_UNLINKED) begin
                                    id_next = offered;
                                    due_next[lhk_pkg::DUE_HSK] = 1'b1;
                                end
                            end
                            lhk_pkg::PK_HSK_ACK: begin
                                if (mode_reg == lhk_pkg::LS_CONNECTING) begin
                                    data_at_next = now;
                                end
                            end
                            lhk_pkg::PK_SPAWN, lhk_pkg::PK_UPDATE, lhk_pkg::PK_DESPAWN: begin
                                data_at_next = now;
                            end
                            default: ;
                        endcase
                    end
                end
                lhk_pkg::REQ_TICK_END: begin
                    if (mode_reg == lhk_pkg::LS_CONNECTED ||
                        mode_reg == lhk_pkg::LS_SPURIOUS) begin
                        input_fire = 1'b1;
                    end
                    if (mode_reg == lhk_pkg::LS_CONNECTED && el_keep) begin
                        ping_fire    = 1'b1;
                        keep_at_next = now;
                    end
                end
                default: ;
            endcase
        end
        ping_cnt_next  = ping_fire ? ping_cnt_reg + 32'd1 : ping_cnt_reg;
        input_cnt_next = input_fire ? input_cnt_reg + 32'd1 : input_cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= lhk_pkg::LS_UNLINKED;
            entered_reg   <= '0;
            hello_at_reg  <= '0;
            hsk_at_reg    <= '0;
            data_at_reg   <= '0;
            probe_at_reg  <= '0;
            keep_at_reg   <= '0;
            due_reg       <= 3'b111;
            ping_cnt_reg  <= '0;
            input_cnt_reg <= '0;
            id_reg        <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (acc) begin
                mode_reg      <= mode_next;
                entered_reg   <= entered_next;
                hello_at_reg  <= hello_at_next;
                hsk_at_reg    <= hsk_at_next;
                data_at_reg   <= data_at_next;
                probe_at_reg  <= probe_at_next;
                keep_at_reg   <= keep_at_next;
                due_reg       <= due_next;
                ping_cnt_reg  <= ping_cnt_next;
                input_cnt_reg <= input_cnt_next;
                id_reg        <= id_next;
                m_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    // Result payload; loaded only when a transaction is accepted.
    always_ff @(posedge aclk) begin
        if (acc) begin
            o_state_reg    <= mode_next;
            o_changed_reg  <= changed;
            o_hello_reg    <= hello_fire;
            o_hsk_reg      <= hsk_fire;
            o_ping_reg     <= ping_fire;
            o_ping_no_reg  <= ping_fire ? ping_cnt_reg : 32'd0;
            o_input_reg    <= input_fire;
            o_input_no_reg <= input_fire ? input_cnt_reg : 32'd0;
            o_id_reg       <= id_next;
            o_up_reg       <= (mode_next == lhk_pkg::LS_CONNECTED) ||
                              (mode_next == lhk_pkg::LS_SPURIOUS);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, o_up_reg, o_id_reg, o_input_no_reg, o_input_reg,
                       o_ping_no_reg, o_ping_reg, o_hsk_reg, o_hello_reg,
                       o_changed_reg, o_state_reg};

    // Disconnected is terminal until reset.
    `LHK_ASSERT_NEXT(a_disc_terminal, aclk, aresetn, mode_reg == lhk_pkg::LS_DISCONNECTED, mode_reg == lhk_pkg::LS_DISCONNECTED)
    // An item taken while disconnected sends nothing and changes nothing.
    `LHK_ASSERT_NEXT(a_disc_quiet, aclk, aresetn, acc && mode_reg == lhk_pkg::LS_DISCONNECTED, !(o_changed_reg || o_hello_reg || o_hsk_reg || o_ping_reg || o_input_reg))
    // Every ping sent advances the ping counter by exactly one.
    `LHK_ASSERT_NEXT(a_ping_count, aclk, aresetn, acc && ping_fire, ping_cnt_reg == $past(ping_cnt_reg) + 32'd1)
    // Input frames are sent only while the link is up.
    `LHK_ASSERT_SAME(a_input_when_up, aclk, aresetn, m_valid_reg && o_input_reg, o_up_reg)

endmodule

@@ test/link_handshake_keepalive_fsm_checker.sv @@
// Checker for the link engine: predicts each result from accepted transactions and compares.
`timescale 1ns / 1ps

module link_handshake_keepalive_fsm_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [2:0]    cfg_index,
    input  logic [15:0]   cfg_wdata,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [63:0]   s_tdata,   // now_ms[31:0], offered_id[63:32]
    input  logic [5:0]    s_tuser,   // req_type[1:0], pkt_kind[4:2], pkt_len_ok[5]
    input  logic          m_tvalid,
    input  logic          m_tready,
    // link_state[2:0], state_changed[3], send_hello[4], send_handshake[5],
    // send_ping[6], ping_number[38:7], send_input[39], input_number[71:40],
    // local_id[103:72], link_up[104], zero fill[111:105]
    input  logic [111:0]  m_tdata,
    output int            mismatch_count,
    output int            open_reports
);

    // Packed so that the first member sits at the top, matching the result bus.
    typedef struct packed {
        logic                 up;
        logic [31:0]          net_id;
        logic [31:0]          frame_no;
        logic                 frame;
        logic [31:0]          ping_no;
        logic                 ping;
        logic                 handshake;
        logic                 hello;
        logic                 changed;
        lhk_pkg::link_state_t state;
    } link_report_t;

    logic [15:0] retransmit_ms;
    logic [15:0] timeout_ms;
    logic [15:0] silence_ms;
    logic [15:0] probe_ms;
    logic [15:0] keepalive_ms;

    lhk_pkg::link_state_t mode;
    logic [31:0] entered_at;
    logic [31:0] hello_at;
    logic [31:0] handshake_at;
    logic [31:0] data_at;
    logic [31:0] probe_at;
    logic [31:0] keepalive_at;
    logic [2:0]  due_now;
    logic [31:0] ping_count;
    logic [31:0] frame_count;
    logic [31:0] net_id;
    logic        moved;

    link_report_t predicted_reports[$];
    link_report_t want;
    link_report_t got;

    initial mismatch_count = 0;
    initial open_reports = 0;

    // Differences are taken modulo 2^32, so a mark in the future reads as long ago.
    function automatic logic timer_expired(input logic [31:0] now, input logic [31:0] mark,
                                           input logic [15:0] span);
        logic [31:0] gap;
        gap = now - mark;
        return gap >= {16'd0, span};
    endfunction

    function automatic void move_to(input lhk_pkg::link_state_t next,
                                    input logic [31:0] now);
        mode = next;
        entered_at = now;
        moved = 1'b1;
    endfunction

    function automatic link_report_t advance_link(input logic [1:0] req,
                                                  input logic [31:0] now,
                                                  input logic [2:0] kind,
                                                  input logic len_ok,
                                                  input logic [31:0] offered);
        link_report_t r;
        r = '0;
        moved = 1'b0;
        if (mode != lhk_pkg::LS_DISCONNECTED) begin
            if (req == lhk_pkg::REQ_TICK_START) begin
                case (mode)
                    lhk_pkg::LS_UNLINKED: begin
                        if (due_now[lhk_pkg::DUE_HELLO] ||
                            timer_expired(now, hello_at, retransmit_ms)) begin
                            r.hello = 1'b1;
                            hello_at = now;
                            due_now[lhk_pkg::DUE_HELLO] = 1'b0;
                        end
                        if (timer_expired(now, entered_at, timeout_ms))
                            move_to(lhk_pkg::LS_DISCONNECTED, now);
                    end
                    lhk_pkg::LS_CONNECTING: begin
                        if (due_now[lhk_pkg::DUE_HSK] ||
                            timer_expired(now, handshake_at, retransmit_ms)) begin
                            r.handshake = 1'b1;
                            handshake_at = now;
                            due_now[lhk_pkg::DUE_HSK] = 1'b0;
                        end
                        if (timer_expired(now, entered_at, timeout_ms))
                            move_to(lhk_pkg::LS_DISCONNECTED, now);
                    end
                    lhk_pkg::LS_CONNECTED: begin
                        if (timer_expired(now, data_at, silence_ms))
                            move_to(lhk_pkg::LS_SPURIOUS, now);
                    end
                    lhk_pkg::LS_SPURIOUS: begin
                        if (due_now[lhk_pkg::DUE_PROBE] ||
                            timer_expired(now, probe_at, probe_ms)) begin
                            r.ping = 1'b1;
                            r.ping_no = ping_count;
                            ping_count = ping_count + 32'd1;
                            probe_at = now;
                            due_now[lhk_pkg::DUE_PROBE] = 1'b0;
                        end
                        if (timer_expired(now, entered_at, timeout_ms))
                            move_to(lhk_pkg::LS_DISCONNECTED, now);
                    end
                    default: ;
                endcase
            end else if (req == lhk_pkg::REQ_PACKET && len_ok) begin
                case (kind)
                    lhk_pkg::PK_HELLO_ACK: begin
                        if (mode == lhk_pkg::LS_UNLINKED) begin
                            net_id = offered;
                            due_now[lhk_pkg::DUE_HSK] = 1'b1;
                            move_to(lhk_pkg::LS_CONNECTING, now);
                        end
                    end
                    lhk_pkg::PK_HSK_ACK: begin
                        if (mode == lhk_pkg::LS_CONNECTING) begin
                            data_at = now;
                            move_to(lhk_pkg::LS_CONNECTED, now);
                        end
                    end
                    lhk_pkg::PK_SPAWN, lhk_pkg::PK_DESPAWN: data_at = now;
                    lhk_pkg::PK_UPDATE: begin
                        data_at = now;
                        if (mode == lhk_pkg::LS_SPURIOUS)
                            move_to(lhk_pkg::LS_CONNECTED, now);
                    end
                    // A ping response revives the link but is not counted as data.
                    lhk_pkg::PK_PING_RESP: begin
                        if (mode == lhk_pkg::LS_SPURIOUS)
                            move_to(lhk_pkg::LS_CONNECTED, now);
                    end
                    default: ;
                endcase
            end else if (req == lhk_pkg::REQ_TICK_END) begin
                if (mode == lhk_pkg::LS_CONNECTED || mode == lhk_pkg::LS_SPURIOUS) begin
                    r.frame = 1'b1;
                    r.frame_no = frame_count;
                    frame_count = frame_count + 32'd1;
                    if (mode == lhk_pkg::LS_CONNECTED &&
                        timer_expired(now, keepalive_at, keepalive_ms)) begin
                        r.ping = 1'b1;
                        r.ping_no = ping_count;
                        ping_count = ping_count + 32'd1;
                        keepalive_at = now;
                    end
                end
            end
        end
        r.state = mode;
        r.changed = moved;
        r.net_id = net_id;
        r.up = (mode == lhk_pkg::LS_CONNECTED || mode == lhk_pkg::LS_SPURIOUS);
        return r;
    endfunction

    task automatic compare_field(input string label, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (want_v !== got_v) begin
            mismatch_count++;
            $display("%0t ns: %s expected %0h, actual %0h", $time, label, want_v, got_v);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            retransmit_ms = lhk_pkg::RST_RETRANSMIT;
            timeout_ms = lhk_pkg::RST_TIMEOUT;
            silence_ms = lhk_pkg::RST_SILENCE;
            probe_ms = lhk_pkg::RST_PROBE;
            keepalive_ms = lhk_pkg::RST_KEEPALIVE;
            mode = lhk_pkg::LS_UNLINKED;
            entered_at = '0;
            hello_at = '0;
            handshake_at = '0;
            data_at = '0;
            probe_at = '0;
            keepalive_at = '0;
            due_now = '1;
            ping_count = '0;
            frame_count = '0;
            net_id = '0;
            predicted_reports.delete();
        end else begin
            // A result leaving now belongs to an earlier transaction, so it is checked first.
            if (m_tvalid && m_tready) begin
                got = link_report_t'(m_tdata[104:0]);
                if (predicted_reports.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: result expected none, actual %0h", $time, m_tdata);
                end else begin
                    want = predicted_reports[0];
                    predicted_reports.delete(0);
                    compare_field("link_state", 32'(want.state), 32'(got.state));
                    compare_field("state_changed", 32'(want.changed), 32'(got.changed));
                    compare_field("send_hello", 32'(want.hello), 32'(got.hello));
                    compare_field("send_handshake", 32'(want.handshake),
                                  32'(got.handshake));
                    compare_field("send_ping", 32'(want.ping), 32'(got.ping));
                    compare_field("ping_number", want.ping_no, got.ping_no);
                    compare_field("send_input", 32'(want.frame), 32'(got.frame));
                    compare_field("input_number", want.frame_no, got.frame_no);
                    compare_field("local_id", want.net_id, got.net_id);
                    compare_field("link_up", 32'(want.up), 32'(got.up));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    lhk_pkg::CFG_RETRANSMIT: retransmit_ms = cfg_wdata;
                    lhk_pkg::CFG_TIMEOUT:    timeout_ms = cfg_wdata;
                    lhk_pkg::CFG_SILENCE:    silence_ms = cfg_wdata;
                    lhk_pkg::CFG_PROBE:      probe_ms = cfg_wdata;
                    lhk_pkg::CFG_KEEPALIVE:  keepalive_ms = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predicted_reports.insert(predicted_reports.size(),
                                         advance_link(s_tuser[1:0], s_tdata[31:0],
                                                      s_tuser[4:2], s_tuser[5],
                                                      s_tdata[63:32]));
        end
        open_reports <= predicted_reports.size();
    end

endmodule

@@ test/tb_link_handshake_keepalive_fsm_core.sv @@
// Testbench top for the link engine: reset, register settings, stimulus and verdict.
`timescale 1ns / 1ps

module tb_link_handshake_keepalive_fsm_core;

    // The block defines no code for the fourth request type; it must be ignored.
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic          aclk;
    logic          aresetn = 1'b0;
    logic          cfg_wr_en = 1'b0;
    logic [2:0]    cfg_index = '0;
    logic [15:0]   cfg_wdata = '0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [63:0]   s_tdata = '0;   // now_ms[31:0], offered_id[63:32]
    logic [5:0]    s_tuser = '0;   // req_type[1:0], pkt_kind[4:2], pkt_len_ok[5]
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    // link_state[2:0], state_changed[3], send_hello[4], send_handshake[5],
    // send_ping[6], ping_number[38:7], send_input[39], input_number[71:40],
    // local_id[103:72], link_up[104], zero fill[111:105]
    logic [111:0]  m_tdata;

    int            mismatch_count;
    int            open_reports;
    int unsigned   cycle_count = 0;
    int unsigned   ready_hold = 0;
    bit            gaps_on = 1'b1;
    bit            stalls_on = 1'b1;
    logic [31:0]   clock_ms = '0;

    link_handshake_keepalive_fsm_core uut (.*);

    link_handshake_keepalive_fsm_checker link_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver back-pressure in bursts; each chosen level holds until ready_hold counts down to zero.
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (stalls_on && $urandom_range(0, 2) == 0) begin
            m_tready <= 1'b0;
            ready_hold <= $urandom_range(0, 8);
        end else begin
            m_tready <= 1'b1;
            ready_hold <= $urandom_range(0, 15);
        end
    end

    task automatic send_item(input logic [1:0] req, input logic [31:0] now,
                             input logic [2:0] kind, input logic len_ok,
                             input logic [31:0] offered);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {offered, now};
        s_tuser <= {len_ok, kind, req};
        do @(posedge aclk); while (!s_tready);
    endtask

    // The first wait skips the last transaction's edge, since open_reports is a registered count.
    task automatic wait_all_done();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (open_reports != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic [15:0] retransmit, input logic [15:0] timeout,
                                 input logic [15:0] silence, input logic [15:0] probe,
                                 input logic [15:0] keepalive);
        write_reg(lhk_pkg::CFG_RETRANSMIT, retransmit);
        write_reg(lhk_pkg::CFG_TIMEOUT, timeout);
        write_reg(lhk_pkg::CFG_SILENCE, silence);
        write_reg(lhk_pkg::CFG_PROBE, probe);
        write_reg(lhk_pkg::CFG_KEEPALIVE, keepalive);
        write_reg(lhk_pkg::CFG_KEEPALIVE + 3'($urandom_range(1, 3)), 16'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    // Time only moves forward for items that touch the timers; items the block must
    // ignore carry arbitrary times and ids.
    task automatic random_item();
        int unsigned pick;
        logic [31:0] any_now;
        logic [31:0] any_id;
        pick = $urandom_range(0, 99);
        any_now = $urandom;
        any_id = $urandom;
        clock_ms = clock_ms + $urandom_range(0, 8);
        if (pick < 30) begin
            send_item(lhk_pkg::REQ_TICK_START, clock_ms, 3'($urandom), 1'($urandom), any_id);
        end else if (pick < 55) begin
            send_item(lhk_pkg::REQ_TICK_END, clock_ms, 3'($urandom), 1'($urandom), any_id);
        end else if (pick < 70) begin
            send_item(lhk_pkg::REQ_PACKET, clock_ms, lhk_pkg::PK_UPDATE, 1'b1, any_id);
        end else if (pick < 78) begin
            send_item(lhk_pkg::REQ_PACKET, clock_ms, lhk_pkg::PK_PING_RESP, 1'b1, any_id);
        end else if (pick < 84) begin
            send_item(lhk_pkg::REQ_PACKET, clock_ms,
                      pick[0] ? lhk_pkg::PK_SPAWN : lhk_pkg::PK_DESPAWN, 1'b1, any_id);
        end else if (pick < 90) begin
            send_item(REQ_UNUSED, any_now, 3'($urandom), 1'($urandom), any_id);
        end else if (pick < 95) begin
            send_item(lhk_pkg::REQ_PACKET, any_now, 3'($urandom), 1'b0, any_id);
        end else begin
            case ($urandom_range(0, 3))
                0: send_item(lhk_pkg::REQ_PACKET, any_now, lhk_pkg::PK_HELLO_ACK, 1'b1, any_id);
                1: send_item(lhk_pkg::REQ_PACKET, any_now, lhk_pkg::PK_HSK_ACK, 1'b1, any_id);
                2: send_item(lhk_pkg::REQ_PACKET, any_now, lhk_pkg::PK_WORLD, 1'b1, any_id);
                default: send_item(lhk_pkg::REQ_PACKET, any_now, lhk_pkg::PK_OTHER, 1'b1,
                                   any_id);
            endcase
        end
    endtask

    initial begin : stimulus
        logic [31:0] mark;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Bring-up under reset settings; the state timer starts at time zero.
        send_item(lhk_pkg::REQ_TICK_START, 32'd0, lhk_pkg::PK_HELLO_ACK, 1'b0, $urandom);
        send_item(lhk_pkg::REQ_TICK_START, 32'd50, lhk_pkg::PK_OTHER, 1'b1, $urandom);
        send_item(lhk_pkg::REQ_TICK_START, 32'd100, lhk_pkg::PK_WORLD, 1'b0, $urandom);
        send_item(lhk_pkg::REQ_PACKET, 32'd110, lhk_pkg::PK_HELLO_ACK, 1'b0, $urandom);
        send_item(lhk_pkg::REQ_PACKET, 32'd120, lhk_pkg::PK_UPDATE, 1'b1, $urandom);
        send_item(lhk_pkg::REQ_PACKET, 32'd121, lhk_pkg::PK_SPAWN, 1'b1, $urandom);
        send_item(lhk_pkg::REQ_PACKET, 32'd122, lhk_pkg::PK_DESPAWN, 1'b1, $urandom);
        send_item(lhk_pkg::REQ_PACKET, 32'd123, lhk_pkg::PK_PING_RESP, 1'b1, $urandom);
        send_item(lhk_pkg::REQ_PACKET, 32'd124, lhk_pkg::PK_WORLD, 1'b1, $urandom);
        send_item(lhk_pkg::REQ_PACKET, 32'd125, lhk_pkg::PK_OTHER, 1'b1, $urandom);
        send_item(lhk_pkg::REQ_PACKET, 32'd126, lhk_pkg::PK_HSK_ACK, 1'b1, $urandom);
        send_item(lhk_pkg::REQ_TICK_END, 32'd130, lhk_pkg::PK_OTHER, 1'b1, $urandom);
        send_item(REQ_UNUSED, 32'hFFFF_FFFF, lhk_pkg::PK_OTHER, 1'b1, 32'd0);

        wait_all_done();
        load_settings(16'd1, lhk_pkg::RST_TIMEOUT, lhk_pkg::RST_SILENCE, lhk_pkg::RST_PROBE,
                      lhk_pkg::RST_KEEPALIVE);
        send_item(lhk_pkg::REQ_TICK_START, 32'd140, lhk_pkg::PK_HELLO_ACK, 1'b0, $urandom);
        send_item(lhk_pkg::REQ_TICK_START, 32'd140, lhk_pkg::PK_HELLO_ACK, 1'b0, $urandom);
        wait_all_done();
        load_settings(16'd0, lhk_pkg::RST_TIMEOUT, lhk_pkg::RST_SILENCE, lhk_pkg::RST_PROBE,
                      lhk_pkg::RST_KEEPALIVE);
        send_item(lhk_pkg::REQ_TICK_START, 32'd140, lhk_pkg::PK_HELLO_ACK, 1'b0, $urandom);
        wait_all_done();
        load_settings(16'hFFFF, 16'hFFFF, lhk_pkg::RST_SILENCE, lhk_pkg::RST_PROBE,
                      lhk_pkg::RST_KEEPALIVE);

        // Jump close to the wrap point so that the clock rolls over during the run.
        clock_ms = 32'hFFFF_FC00 + $urandom_range(0, 511);
        send_item(lhk_pkg::REQ_PACKET, clock_ms, lhk_pkg::PK_HELLO_ACK, 1'b1, 32'hFFFF_FFFF);
        send_item(lhk_pkg::REQ_PACKET, clock_ms, lhk_pkg::PK_HELLO_ACK, 1'b1, 32'd0);
        send_item(lhk_pkg::REQ_TICK_START, clock_ms, lhk_pkg::PK_OTHER, 1'b0, $urandom);
        send_item(lhk_pkg::REQ_TICK_START, clock_ms + 1, lhk_pkg::PK_OTHER, 1'b0, $urandom);
        send_item(lhk_pkg::REQ_PACKET, clock_ms + 1, lhk_pkg::PK_HSK_ACK, 1'b0, $urandom);
        send_item(lhk_pkg::REQ_PACKET, clock_ms + 2, lhk_pkg::PK_HSK_ACK, 1'b1, $urandom);
        send_item(lhk_pkg::REQ_TICK_END, clock_ms + 2, lhk_pkg::PK_OTHER, 1'b0, $urandom);
        send_item(lhk_pkg::REQ_TICK_END, clock_ms + 3, lhk_pkg::PK_OTHER, 1'b0, $urandom);
        send_item(lhk_pkg::REQ_TICK_START, clock_ms + 102, lhk_pkg::PK_OTHER, 1'b0, $urandom);
        send_item(lhk_pkg::REQ_TICK_START, clock_ms + 102, lhk_pkg::PK_OTHER, 1'b0, $urandom);
        send_item(lhk_pkg::REQ_TICK_END, clock_ms + 103, lhk_pkg::PK_OTHER, 1'b0, $urandom);
        send_item(lhk_pkg::REQ_PACKET, clock_ms + 104, lhk_pkg::PK_PING_RESP, 1'b1, $urandom);
        clock_ms = clock_ms + 104;

        // Each phase starts from an idle block, which also gives the sender a full pause.
        for (int phase = 0; phase < 6; phase++) begin
            wait_all_done();
            gaps_on = (phase != 2 && phase != 5);
            stalls_on = (phase != 2 && phase != 5);
            case (phase)
                0: load_settings(16'hFFFF, lhk_pkg::RST_TIMEOUT, lhk_pkg::RST_SILENCE,
                                 lhk_pkg::RST_PROBE, lhk_pkg::RST_KEEPALIVE);
                1: load_settings(16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd0);
                2: load_settings(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                4: load_settings(lhk_pkg::RST_RETRANSMIT, 16'd2000, 16'd1, 16'd1, 16'd1);
                default: load_settings(16'($urandom_range(1, 65535)),
                                       16'($urandom_range(2000, 65535)),
                                       16'($urandom_range(1, 40)),
                                       16'($urandom_range(1, 40)),
                                       16'($urandom_range(1, 60)));
            endcase
            repeat (200) random_item();
        end

        // Drive the link into its terminal state, with a probe in the same tick.
        wait_all_done();
        load_settings(lhk_pkg::RST_RETRANSMIT, 16'd1, 16'd0, 16'd0, lhk_pkg::RST_KEEPALIVE);
        mark = clock_ms + 1;
        send_item(lhk_pkg::REQ_PACKET, mark, lhk_pkg::PK_UPDATE, 1'b1, $urandom);
        send_item(lhk_pkg::REQ_TICK_START, mark, lhk_pkg::PK_OTHER, 1'b0, $urandom);
        send_item(lhk_pkg::REQ_TICK_START, mark, lhk_pkg::PK_OTHER, 1'b0, $urandom);
        send_item(lhk_pkg::REQ_TICK_END, mark, lhk_pkg::PK_OTHER, 1'b0, $urandom);
        wait_all_done();
        load_settings(lhk_pkg::RST_RETRANSMIT, 16'd0, 16'd0, 16'd0, lhk_pkg::RST_KEEPALIVE);
        send_item(lhk_pkg::REQ_TICK_START, mark, lhk_pkg::PK_OTHER, 1'b0, $urandom);
        send_item(lhk_pkg::REQ_PACKET, mark, lhk_pkg::PK_UPDATE, 1'b1, $urandom);
        send_item(lhk_pkg::REQ_PACKET, mark, lhk_pkg::PK_PING_RESP, 1'b1, $urandom);
        send_item(lhk_pkg::REQ_TICK_START, mark + 5000, lhk_pkg::PK_OTHER, 1'b1, $urandom);
        send_item(lhk_pkg::REQ_TICK_END, mark, lhk_pkg::PK_OTHER, 1'b1, $urandom);
        send_item(lhk_pkg::REQ_PACKET, mark, lhk_pkg::PK_HELLO_ACK, 1'b1, $urandom);
        send_item(REQ_UNUSED, mark, lhk_pkg::PK_OTHER, 1'b1, $urandom);

        wait_all_done();
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0 && open_reports == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
